// ----- rtl/buddy_block_allocator_core_macros.svh -----
// Assertion helpers for the allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_MACROS_SVH
// Check a property on every clock, quiet during reset
`define BBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property including reset
`define BBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ----- rtl/bba_pkg.sv -----
package bba_pkg;
  localparam int unsigned LevelsDef   = 4;
  localparam int unsigned TagWidthDef = 16;
  localparam int unsigned SizeWidth   = 16;
  localparam logic [SizeWidth-1:0] TotalSizeReset = 16'd1024;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_OCC   = 2'd1,
    ST_SPLIT = 2'd2
  } node_st_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VISIT,
    S_NEXT,
    S_MERGE,
    S_DONE
  } fsm_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // latch request, go to root
    logic visit;    // act on current node
    logic next;     // advance walk pointer
    logic merge;    // one merge step upward
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;      // current node satisfied the request
    logic climb;    // walk climbs out of a finished right child
    logic end_walk; // no more nodes to try
    logic merge_go; // parent can merge
  } sts_t;
endpackage

// ----- rtl/bba_ctrl.sv -----
module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output logic          ok_o,
  input  logic          cmd_i,
  output bba_pkg::ctl_t ctl_o,
  input  bba_pkg::sts_t sts_i
);
  bba_pkg::fsm_e state_q, state_d;
  logic cmd_q, cmd_d, ok_q, ok_d;

  // Hold state and request kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_IDLE;
      cmd_q   <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      ok_q    <= ok_d;
    end
  end

  // Sequence the tree walk
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ok_d    = ok_q;
    ctl_o   = '0;
    case (state_q)
      bba_pkg::S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          cmd_d      = cmd_i;
          state_d    = bba_pkg::S_VISIT;
        end
      end
      bba_pkg::S_VISIT: begin
        ctl_o.visit = 1'b1;
        if (sts_i.hit) begin
          ok_d    = 1'b1;
          state_d = (cmd_q == bba_pkg::CMD_FREE) ? bba_pkg::S_MERGE : bba_pkg::S_DONE;
        end else if (sts_i.end_walk) begin
          ok_d    = 1'b0;
          state_d = bba_pkg::S_DONE;
        end else begin
          state_d = bba_pkg::S_NEXT;
        end
      end
      // Stay here while climbing out of right children
      bba_pkg::S_NEXT: begin
        ctl_o.next = 1'b1;
        if (sts_i.end_walk) begin
          ok_d    = 1'b0;
          state_d = bba_pkg::S_DONE;
        end else if (!sts_i.climb) begin
          state_d = bba_pkg::S_VISIT;
        end
      end
      bba_pkg::S_MERGE: begin
        if (sts_i.merge_go) ctl_o.merge = 1'b1;
        else state_d = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: state_d = bba_pkg::S_IDLE;
      default: state_d = bba_pkg::S_IDLE;
    endcase
  end

  assign busy_o = (state_q != bba_pkg::S_IDLE);
  assign done_o = (state_q == bba_pkg::S_DONE);
  assign ok_o   = ok_q;
endmodule

// ----- rtl/bba_dpath.sv -----
module bba_dpath #(
  parameter int unsigned LEVELS    = bba_pkg::LevelsDef,
  parameter int unsigned TAG_WIDTH = bba_pkg::TagWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::SizeWidth-1:0] cfg_data_i,
  input  logic                          cmd_i,
  input  logic [TAG_WIDTH-1:0]          tag_i,
  input  logic [bba_pkg::SizeWidth-1:0] req_size_i,
  input  bba_pkg::ctl_t                 ctl_i,
  output bba_pkg::sts_t                 sts_o
);
  localparam int unsigned Nodes = (1 << (LEVELS + 1)) - 1;
  localparam int unsigned IdxW  = $clog2(Nodes);
  localparam int unsigned DepW  = $clog2(LEVELS + 1);
  localparam int unsigned SW    = bba_pkg::SizeWidth;

  logic [SW-1:0]        total_q;
  logic [1:0]           st_q [Nodes];
  logic [TAG_WIDTH-1:0] tag_mem [Nodes];
  logic [TAG_WIDTH-1:0] tag_rd_q;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [DepW-1:0]      dep_q, dep_d;
  logic                 cmd_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [SW-1:0]        req_q;

  // Current node view
  logic [SW-1:0]   size;
  logic [1:0]      cur;
  logic            is_leaf, fits, take, alloc_hit, free_hit, want_desc;
  logic [IdxW-1:0] left, right, parent, sib;
  logic            is_left, can_merge;

  always_comb begin
    size      = total_q >> dep_q;
    cur       = st_q[idx_q];
    is_leaf   = (dep_q >= DepW'(LEVELS));
    left      = IdxW'({idx_q, 1'b1});
    right     = IdxW'({idx_q, 1'b0} + IdxW'(2));
    is_left   = idx_q[0];
    parent    = (idx_q - IdxW'(1)) >> 1;
    sib       = is_left ? idx_q + IdxW'(1) : idx_q - IdxW'(1);
    fits      = (cur != bba_pkg::ST_OCC) && (req_q <= size);
    take      = (req_q == size) || (req_q > (size >> 1));
    alloc_hit = fits && (cur == bba_pkg::ST_FREE) && (take || is_leaf);
    free_hit  = (cur == bba_pkg::ST_OCC) && (tag_rd_q == tag_q);
    // Descend on a split node or on a free node that gets split
    if (cmd_q == bba_pkg::CMD_ALLOC)
      want_desc = fits && !take && !is_leaf;
    else
      want_desc = (cur == bba_pkg::ST_SPLIT) && !is_leaf;
    can_merge = (idx_q != '0) && (st_q[parent] == bba_pkg::ST_SPLIT) &&
                (st_q[sib] == bba_pkg::ST_FREE) &&
                (st_q[idx_q] == bba_pkg::ST_FREE);
  end

  // Backtrack: climb while on a right child, then move to the right sibling
  logic [IdxW-1:0] bt_idx;
  logic [DepW-1:0] bt_dep;
  logic            desc_q;

  // Walk pointer: the tree has at most LEVELS+1 depths, so climb one per step
  always_comb begin
    sts_o          = '0;
    sts_o.hit      = (cmd_q == bba_pkg::CMD_ALLOC) ? alloc_hit : free_hit;
    sts_o.climb    = !desc_q && !is_left && (idx_q != '0);
    bt_idx         = idx_q;
    bt_dep         = dep_q;
    if (ctl_i.next && !desc_q) begin
      if (is_left) begin
        bt_idx = idx_q + IdxW'(1);
      end else if (idx_q != '0) begin
        bt_idx = parent;
        bt_dep = dep_q - DepW'(1);
      end
    end
    sts_o.end_walk = ctl_i.visit ? (!sts_o.hit && !want_desc && idx_q == '0)
                                 : (!desc_q && idx_q == '0);
    sts_o.merge_go = can_merge;
    idx_d = idx_q;
    dep_d = dep_q;
    if (ctl_i.load) begin
      idx_d = '0;
      dep_d = '0;
    end else if (ctl_i.next) begin
      if (desc_q) begin
        idx_d = left;
        dep_d = dep_q + DepW'(1);
      end else begin
        idx_d = bt_idx;
        dep_d = bt_dep;
      end
    end else if (ctl_i.merge) begin
      idx_d = parent;
      dep_d = dep_q - DepW'(1);
    end
  end

  // Walk registers; a right child climbs through NEXT until a left child
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      dep_q   <= '0;
      desc_q  <= 1'b0;
      cmd_q   <= 1'b0;
      total_q <= bba_pkg::TotalSizeReset;
    end else begin
      idx_q <= idx_d;
      dep_q <= dep_d;
      if (cfg_we_i) total_q <= cfg_data_i;
      if (ctl_i.load) begin
        cmd_q  <= cmd_i;
        desc_q <= 1'b0;
      end else if (ctl_i.visit) begin
        desc_q <= want_desc;
      end else if (ctl_i.next && !desc_q && !is_left && idx_q != '0) begin
        desc_q <= 1'b0;
      end
    end
  end

  // Payload of the request
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      tag_q <= tag_i;
      req_q <= req_size_i;
    end
  end

  // Node status array: clear on reset, update on visit and merge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Nodes; i++) st_q[i] <= bba_pkg::ST_FREE;
    end else if (ctl_i.visit) begin
      if (cmd_q == bba_pkg::CMD_ALLOC) begin
        if (alloc_hit) begin
          st_q[idx_q] <= bba_pkg::ST_OCC;
        end else if (want_desc && cur == bba_pkg::ST_FREE) begin
          st_q[idx_q] <= bba_pkg::ST_SPLIT;
          st_q[left]  <= bba_pkg::ST_FREE;
          st_q[right] <= bba_pkg::ST_FREE;
        end
      end else if (free_hit) begin
        st_q[idx_q] <= bba_pkg::ST_FREE;
      end
    end else if (ctl_i.merge) begin
      st_q[parent] <= bba_pkg::ST_FREE;
    end
  end

  // Tags written on allocate; read the node the walk moves to next
  always_ff @(posedge clk_i) begin
    if (ctl_i.visit && cmd_q == bba_pkg::CMD_ALLOC && alloc_hit)
      tag_mem[idx_q] <= tag_q;
    tag_rd_q <= tag_mem[idx_d];
  end
endmodule

// ----- rtl/buddy_block_allocator_core.sv -----
// Buddy block allocator core.
// Command channel: raise start with cmd_i, tag_i and req_size_i while busy is
// low; the word is taken on that edge. cmd 0 allocates a block of req_size_i,
// cmd 1 frees the first occupied block whose tag matches.
// Result: done_o strobes for one cycle with ok_o; the receiver cannot stall,
// so it must take ok_o while done_o is high.
// Walk: each node is handled in a visit state and then a move state, and the
// walk stays in the move state while it climbs out of right children, one
// level per step. A free then checks for a merge and merges one level per
// step while the buddies are free. The next word is taken the cycle after
// done_o at earliest.
// Configuration: total_size is written through cfg_valid/cfg_ready while idle;
// cfg_ready is high whenever busy is low.
// Reset: all nodes free, total_size 1024, no request in flight.
`include "buddy_block_allocator_core_macros.svh"
module buddy_block_allocator_core #(
  parameter int unsigned LEVELS    = bba_pkg::LevelsDef,
  parameter int unsigned TAG_WIDTH = bba_pkg::TagWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd_i,
  input  logic [TAG_WIDTH-1:0]          tag_i,
  input  logic [bba_pkg::SizeWidth-1:0] req_size_i,
  output logic                          done_o,
  output logic                          ok_o,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::SizeWidth-1:0] cfg_data_i
);
  bba_pkg::ctl_t ctl;
  bba_pkg::sts_t sts;

  assign cfg_ready = !busy;

  bba_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_o(busy), .done_o(done_o),
    .ok_o(ok_o), .cmd_i(cmd_i), .ctl_o(ctl), .sts_i(sts)
  );

  bba_dpath #(.LEVELS(LEVELS), .TAG_WIDTH(TAG_WIDTH)) u_dpath (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_valid && cfg_ready),
    .cfg_data_i(cfg_data_i), .cmd_i(cmd_i), .tag_i(tag_i), .req_size_i(req_size_i),
    .ctl_i(ctl), .sts_o(sts)
  );

  // Walk and merge never overlap, and results only come while busy
  `BBA_ASSERT(a_one_cmd, $onehot0(ctl), "overlapping commands")
  `BBA_ASSERT(a_done_busy, done_o |-> busy, "result outside a request")
  `BBA_ASSERT(a_load_idle, ctl.load |=> busy, "load did not start a walk")
endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Levels = bba_pkg::LevelsDef;
  localparam int unsigned Nodes  = (1 << (Levels + 1)) - 1;

  typedef struct packed {
    logic                          is_cfg;
    logic [bba_pkg::SizeWidth-1:0] cfg_size;
    bba_pkg::cmd_e                 cmd;
    logic [15:0]                   tag;
    logic [15:0]                   req_size;
    logic [1:0]                    gap;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic cmd_i = 1'b0;
  logic [15:0] tag_i = '0;
  logic [15:0] req_size_i = '0;
  logic cfg_valid = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic busy, done_o, ok_o, cfg_ready;

  word_t pending_q[$];
  logic  ok_q[$];
  int    n_fail = 0;
  bit    drv_idle = 1'b0;

  // allocator mirror
  bba_pkg::node_st_e             tree_st[Nodes];
  logic [15:0]                   tree_tag[Nodes];
  logic [bba_pkg::SizeWidth-1:0] region_size;

  buddy_block_allocator_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .tag_i(tag_i), .req_size_i(req_size_i),
    .done_o(done_o), .ok_o(ok_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit place_block(int idx, int depth, int req, logic [15:0] tg);
    int sz;
    int l;
    sz = int'(region_size) >> depth;
    l = 2 * idx + 1;
    if (idx >= Nodes || tree_st[idx] == bba_pkg::ST_OCC || req > sz) return 1'b0;
    if (req == sz || req > sz / 2) begin
      if (tree_st[idx] != bba_pkg::ST_FREE) return 1'b0;
      tree_st[idx] = bba_pkg::ST_OCC;
      tree_tag[idx] = tg;
      return 1'b1;
    end
    if (tree_st[idx] == bba_pkg::ST_FREE) begin
      if (depth >= Levels) begin
        tree_st[idx] = bba_pkg::ST_OCC;
        tree_tag[idx] = tg;
        return 1'b1;
      end
      tree_st[idx] = bba_pkg::ST_SPLIT;
      tree_st[l] = bba_pkg::ST_FREE;
      tree_st[l + 1] = bba_pkg::ST_FREE;
      return place_block(l, depth + 1, req, tg);
    end
    if (depth >= Levels) return 1'b0;
    if (place_block(l, depth + 1, req, tg)) return 1'b1;
    return place_block(l + 1, depth + 1, req, tg);
  endfunction

  function automatic int owner_node(int idx, int depth, logic [15:0] tg);
    int r;
    if (idx >= Nodes) return -1;
    if (tree_st[idx] == bba_pkg::ST_OCC) return (tree_tag[idx] == tg) ? idx : -1;
    if (tree_st[idx] != bba_pkg::ST_SPLIT || depth >= Levels) return -1;
    r = owner_node(2 * idx + 1, depth + 1, tg);
    if (r >= 0) return r;
    return owner_node(2 * idx + 2, depth + 1, tg);
  endfunction

  function automatic bit release_block(logic [15:0] tg);
    int i;
    int p;
    i = owner_node(0, 0, tg);
    if (i < 0) return 1'b0;
    tree_st[i] = bba_pkg::ST_FREE;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (tree_st[p] == bba_pkg::ST_SPLIT && tree_st[2*p+1] == bba_pkg::ST_FREE &&
          tree_st[2*p+2] == bba_pkg::ST_FREE) begin
        tree_st[p] = bba_pkg::ST_FREE;
        i = p;
      end else break;
    end
    return 1'b1;
  endfunction

  // Feed words to the command and config channels
  always @(posedge clk_i) begin
    static int wait_cnt = 0;
    word_t w;
    if (rst_ni) begin
      if (start && !busy) begin
        start <= 1'b0;
        void'(pending_q.pop_front());
      end else if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
        void'(pending_q.pop_front());
      end else if (!start && !cfg_valid && pending_q.size() > 0) begin
        w = pending_q[0];
        if (w.is_cfg) begin
          // write only once everything has drained
          if (ok_q.size() == 0 && !busy && !done_o) begin
            cfg_valid <= 1'b1;
            cfg_data_i <= w.cfg_size;
            region_size = w.cfg_size;
          end
        end else if (wait_cnt < w.gap) begin
          wait_cnt++;
        end else begin
          wait_cnt = 0;
          start <= 1'b1;
          cmd_i <= w.cmd;
          tag_i <= w.tag;
          req_size_i <= w.req_size;
          if (w.cmd == bba_pkg::CMD_ALLOC)
            ok_q.push_back(place_block(0, 0, w.req_size, w.tag));
          else ok_q.push_back(release_block(w.tag));
        end
      end
      drv_idle <= (pending_q.size() == 0) && !start && !cfg_valid;
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    logic exp_ok;
    if (rst_ni && done_o) begin
      if (ok_q.size() == 0) begin
        $error("unexpected result word ok=%0b", ok_o);
        n_fail++;
      end else begin
        exp_ok = ok_q.pop_front();
        if (ok_o !== exp_ok) begin
          $error("ok: expected %0b actual %0b", exp_ok, ok_o);
          n_fail++;
        end
      end
    end
  end

  task automatic push_op(bba_pkg::cmd_e c, int tg, int rs);
    word_t w;
    w = '0;
    w.cmd = c;
    w.tag = tg[15:0];
    w.req_size = rs[15:0];
    w.gap = ($urandom_range(0, 3) == 0) ? 2'd0 : 2'($urandom_range(0, 3));
    pending_q.push_back(w);
  endtask

  task automatic push_cfg(int sz);
    word_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.cfg_size = sz[15:0];
    pending_q.push_back(w);
  endtask

  task automatic random_phase(int n, int cfg_sz);
    int tags[$];
    int sz;
    push_cfg(cfg_sz);
    for (int k = 0; k < n; k++) begin
      if (tags.size() > 0 && $urandom_range(0, 99) < 40) begin
        int j;
        j = $urandom_range(0, tags.size() - 1);
        push_op(bba_pkg::CMD_FREE, tags[j], $urandom);
        tags.delete(j);
      end else if ($urandom_range(0, 99) < 8) begin
        push_op($urandom_range(0, 1) ? bba_pkg::CMD_FREE : bba_pkg::CMD_ALLOC,
                $urandom, $urandom);
      end else begin
        sz = (cfg_sz == 0) ? 1 : cfg_sz;
        case ($urandom_range(0, 3))
          0: sz = $urandom_range(0, 3);
          1: sz = $urandom_range(0, sz);
          2: sz = sz >> $urandom_range(0, Levels);
          default: sz = $urandom_range(0, (sz >> $urandom_range(0, Levels)) + 1);
        endcase
        tags.push_back($urandom_range(0, 65535));
        push_op(bba_pkg::CMD_ALLOC, tags[$], sz);
      end
    end
    // clear remaining blocks so the next phase starts near empty
    foreach (tags[j]) push_op(bba_pkg::CMD_FREE, tags[j], 0);
  endtask

  initial begin
    static int sizes[] = '{1024, 65535, 1, 0, 16, 100, 37, 32768, 7};
    for (int i = 0; i < Nodes; i++) tree_st[i] = bba_pkg::ST_FREE;
    region_size = bba_pkg::TotalSizeReset;
    // directed: extremes, zero request, duplicates, unknown tag
    push_op(bba_pkg::CMD_ALLOC, 16'hFFFF, 1024);
    push_op(bba_pkg::CMD_ALLOC, 16'h0001, 1);
    push_op(bba_pkg::CMD_FREE, 16'hFFFF, 16'hFFFF);
    push_op(bba_pkg::CMD_ALLOC, 16'h0000, 0);
    push_op(bba_pkg::CMD_ALLOC, 16'h00AA, 64);
    push_op(bba_pkg::CMD_ALLOC, 16'h00AA, 64);
    push_op(bba_pkg::CMD_FREE, 16'h00AA, 0);
    push_op(bba_pkg::CMD_FREE, 16'h1234, 5);
    push_op(bba_pkg::CMD_ALLOC, 16'h5555, 16'hFFFF);
    push_op(bba_pkg::CMD_ALLOC, 16'hAAAA, 512);
    push_op(bba_pkg::CMD_ALLOC, 16'h7777, 513);
    push_op(bba_pkg::CMD_FREE, 16'h0001, 0);
    push_op(bba_pkg::CMD_FREE, 16'h0000, 0);
    push_op(bba_pkg::CMD_FREE, 16'h00AA, 0);
    push_op(bba_pkg::CMD_FREE, 16'hAAAA, 0);
    push_cfg(0);
    push_op(bba_pkg::CMD_ALLOC, 16'h0101, 1);
    push_op(bba_pkg::CMD_ALLOC, 16'h0202, 0);
    push_op(bba_pkg::CMD_ALLOC, 16'h0303, 0);
    push_op(bba_pkg::CMD_FREE, 16'h0202, 0);
    push_cfg(65535);
    push_op(bba_pkg::CMD_ALLOC, 16'h8000, 65535);
    push_op(bba_pkg::CMD_FREE, 16'h8000, 0);
    foreach (sizes[i]) random_phase(165, sizes[i]);
    push_cfg(1024);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (drv_idle && ok_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_fail == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Bound the run
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
